// ===== rtl/ihct_pkg.sv =====
// shared types, constants and helpers for the inner hair cell transmitter model
`timescale 1ns / 1ps
package ihct_pkg;

  localparam int NUM_W   = 64;
  localparam int DEN_W   = 40;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int Q_W     = 46;
  localparam int POOL_W  = 32;
  localparam int RATE_W  = 18;
  localparam int OUT_W   = 24;
  localparam int FRAC_W  = 24;
  localparam int K_W     = 25;
  localparam int EJECT_W = 33;
  localparam int SUM_W   = 49;
  localparam int DEF_SAMPLE_WIDTH = 24;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
  localparam logic [23:0] OFFSET_A   = 24'd327680;    // 5 in q16
  localparam logic [31:0] HALF_SAT_B = 32'd19660800;  // 300 in q16
  localparam logic [15:0] PERM_G     = 16'd2000;
  localparam logic [15:0] REPL_NUM   = 16'd505;
  localparam logic [15:0] REPR_NUM   = 16'd6631;
  localparam logic [6:0]  RATE_DEN   = 7'd100;
  localparam logic [15:0] LOSS_L     = 16'd2500;
  localparam logic [15:0] REUP_R     = 16'd6580;
  localparam logic [15:0] GAIN_H     = 16'd50000;
  localparam logic [K_W-1:0] ONE_Q24 = 25'h1000000;
  localparam logic [OUT_W-1:0] OUT_MAX = 24'hFFFFFF;

  localparam logic [63:0] REST_DEN  = 64'd38985470;
  localparam logic [63:0] REST_SDEN = 64'd38985470 * 64'd6631;
  localparam logic [63:0] REST_FREE_W =
    (64'd13985470 * 64'd16777216 + REST_DEN / 64'd2) / REST_DEN;
  localparam logic [63:0] REST_CLEFT_W =
    (64'd50500 * 64'd16777216 + REST_DEN / 64'd2) / REST_DEN;
  localparam logic [63:0] REST_STORE_W =
    (64'd33229000000 * 64'd16777216 + REST_SDEN / 64'd2) / REST_SDEN;
  localparam logic [POOL_W-1:0] REST_FREE  = REST_FREE_W[POOL_W-1:0];
  localparam logic [POOL_W-1:0] REST_CLEFT = REST_CLEFT_W[POOL_W-1:0];
  localparam logic [POOL_W-1:0] REST_STORE = REST_STORE_W[POOL_W-1:0];

  // one divide per rate term, run in this order
  typedef enum logic [2:0] {
    OP_FRAC = 3'd0,
    OP_K    = 3'd1,
    OP_REPL = 3'd2,
    OP_LOSS = 3'd3,
    OP_REUP = 3'd4,
    OP_REPR = 3'd5
  } op_e;

  typedef struct packed {
    logic load;
    logic start;
    logic save;
    logic eject;
    logic update;
    logic emit;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_full;
  } status_t;

  function automatic logic [POOL_W-1:0] clamp_pool(input logic signed [SUM_W-1:0] v);
    logic [POOL_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(SUM_W-POOL_W){1'b0}}, {POOL_W{1'b1}}})) begin
      r = '1;
    end else begin
      r = v[POOL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ihct_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ihct_div
  import ihct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/ihct_ctrl.sv =====
// sequencing state machine for one sample
`timescale 1ns / 1ps
module ihct_ctrl
  import ihct_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_START  = 7'b0000010,
    ST_WAIT   = 7'b0000100,
    ST_SAVE   = 7'b0001000,
    ST_EJECT  = 7'b0010000,
    ST_UPDATE = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d    = OP_FRAC;
          state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_SAVE;
        end
      end
      ST_SAVE: begin
        cmd_o.save = 1'b1;
        state_d = ST_START;
        case (op_q)
          OP_FRAC: op_d = OP_K;
          OP_K:    op_d = OP_REPL;
          OP_REPL: op_d = OP_LOSS;
          OP_LOSS: op_d = OP_REUP;
          OP_REUP: op_d = OP_REPR;
          default: state_d = ST_EJECT;
        endcase
      end
      ST_EJECT: begin
        cmd_o.eject = 1'b1;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.out_full) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_FRAC;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ===== rtl/ihct_dp.sv =====
// datapath: pools, rate terms, shared divider and output register
`timescale 1ns / 1ps
module ihct_dp
  import ihct_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                    last_i,
  input  logic                    cfg_we_i,
  input  logic [RATE_W-1:0]       cfg_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OUT_W-1:0]        out_data_o,
  output logic                    out_last_o
);

  localparam int T_W = SAMPLE_WIDTH + 4;

  logic [RATE_W-1:0]  rate_q;
  logic [POOL_W-1:0]  free_q, cleft_q, store_q;
  logic [T_W-1:0]     t_q;
  logic               last_q;
  logic [FRAC_W-1:0]  frac_q;
  logic [K_W-1:0]     k_q;
  logic [Q_W-1:0]     repl_q, loss_q, reup_q, repr_q;
  logic [EJECT_W-1:0] eject_q;
  logic               out_valid_q;
  logic [OUT_W-1:0]   out_data_q;
  logic               out_last_q;

  logic signed [T_W-1:0] shifted;
  logic [RATE_W-1:0]  fs;
  logic [DEN_W-1:0]   fs100;
  logic [K_W-1:0]     gap;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic               div_done;
  logic [NUM_W-1:0]   quo;
  logic [57:0]        eject_prod;
  logic signed [SUM_W-1:0] free_sum, cleft_sum, store_sum;
  logic [47:0]        gain_prod;
  logic [31:0]        gain_shift;

  assign shifted = T_W'($signed(sample_i)) + $signed(T_W'(OFFSET_A));
  assign fs      = (rate_q == '0) ? RATE_W'(1) : rate_q;
  assign fs100   = DEN_W'(fs) * DEN_W'(RATE_DEN);
  assign gap     = ({1'b0, free_q} < 33'(ONE_Q24)) ? (ONE_Q24 - K_W'(free_q)) : '0;

  always_comb begin
    num = '0;
    den = DEN_W'(fs);
    case (cmd_i.op)
      OP_FRAC: begin
        num = NUM_W'(t_q) << FRAC_W;
        den = DEN_W'(t_q) + DEN_W'(HALF_SAT_B);
      end
      OP_K:    num = NUM_W'(frac_q) * NUM_W'(PERM_G);
      OP_REPL: begin
        num = NUM_W'(gap) * NUM_W'(REPL_NUM);
        den = fs100;
      end
      OP_LOSS: num = NUM_W'(cleft_q) * NUM_W'(LOSS_L);
      OP_REUP: num = NUM_W'(cleft_q) * NUM_W'(REUP_R);
      OP_REPR: begin
        num = NUM_W'(store_q) * NUM_W'(REPR_NUM);
        den = fs100;
      end
      default: num = '0;
    endcase
  end

  ihct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign eject_prod = 58'(k_q) * 58'(free_q);
  assign free_sum  = SUM_W'(free_q) + SUM_W'(repl_q) + SUM_W'(repr_q) - SUM_W'(eject_q);
  assign cleft_sum = SUM_W'(cleft_q) + SUM_W'(eject_q) - SUM_W'(loss_q) - SUM_W'(reup_q);
  assign store_sum = SUM_W'(store_q) + SUM_W'(reup_q) - SUM_W'(repr_q);
  assign gain_prod  = 48'(cleft_q) * 48'(GAIN_H);
  assign gain_shift = gain_prod[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RATE_RESET;
      free_q      <= REST_FREE;
      cleft_q     <= REST_CLEFT;
      store_q     <= REST_STORE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_data_i;
      end
      if (cmd_i.update) begin
        free_q  <= clamp_pool(free_sum);
        cleft_q <= clamp_pool(cleft_sum);
        store_q <= clamp_pool(store_sum);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q    <= shifted[T_W-1] ? '0 : shifted;
      last_q <= last_i;
    end
    if (cmd_i.save) begin
      case (cmd_i.op)
        OP_FRAC: frac_q <= quo[FRAC_W-1:0];
        OP_K:    k_q    <= (quo > NUM_W'(ONE_Q24)) ? ONE_Q24 : quo[K_W-1:0];
        OP_REPL: repl_q <= quo[Q_W-1:0];
        OP_LOSS: loss_q <= quo[Q_W-1:0];
        OP_REUP: reup_q <= quo[Q_W-1:0];
        default: repr_q <= quo[Q_W-1:0];
      endcase
    end
    if (cmd_i.eject) begin
      eject_q <= eject_prod[FRAC_W +: EJECT_W];
    end
    if (cmd_i.emit) begin
      out_data_q <= (gain_shift > 32'(OUT_MAX)) ? OUT_MAX : gain_shift[OUT_W-1:0];
      out_last_q <= last_q;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/inner_hair_cell_transmitter_model.sv =====
// top level of the inner hair cell transmitter model
`timescale 1ns / 1ps
// usage
// - slave stream takes one audio sample per item, signed q8.16 in tdata,
//   tlast marks the final sample of a block and is carried to the result
// - master stream returns one firing rate per sample, unsigned q16.8,
//   with the tlast of that sample
// - cfg port writes the sample rate in hertz (18 bits); it is always ready
//   and is meant to be written only while no sample is in flight
// - each sample runs six divides on one shared bit-serial divider
//   (each in steps: start, quotient bits, done and store), then the
//   eject product, the pool update and the output product; a new sample
//   is accepted only after the previous sample's result has been
//   written to the output register
// - the result sits in an output register, so the next sample is taken
//   while the previous result still waits; a stalled receiver only holds
//   the sequencer once a second result is ready
// - reset puts the three pools at their resting levels, the sample
//   rate at 44100 and empties the output register
module inner_hair_cell_transmitter_model
  import ihct_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [SAMPLE_WIDTH-1:0] sample, zero padded to whole bytes
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [23:0] firing_rate
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [RATE_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // config register is a plain flop, never busy
  assign cfg_ready = 1'b1;

  ihct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ihct_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .last_i      (s_axis_tlast),
    .cfg_we_i    (cfg_valid),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
